@@ sv/trrf_pkg.sv @@
// ----------------------------------------------------------------------------
// trrf_pkg
// Shared widths, register map, reset values and struct types of the
// row run finder.
// ----------------------------------------------------------------------------
package trrf_pkg;

    localparam int PIX_W          = 8;
    localparam int COL_W          = 10;
    localparam int OFF_W          = COL_W + 1;
    localparam int ROW_PIXELS_MAX = 1024;
    localparam int ROW_CNT_W      = $clog2(ROW_PIXELS_MAX + 1);

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [COL_W-1:0] COL_MAX = '1;

    // Register reset values
    localparam logic [PIX_W-1:0] RST_DARK_THRESHOLD = PIX_W'(100);
    localparam logic [COL_W-1:0] RST_MIN_RUN_SPAN   = COL_W'(10);
    localparam logic [COL_W-1:0] RST_FIRST_COLUMN   = COL_W'(80);
    localparam logic [COL_W-1:0] RST_CENTER_COLUMN  = COL_W'(160);

    // Register index (paddr[3:2])
    typedef enum logic [1:0] {
        REG_DARK_THRESHOLD = 2'd0,
        REG_MIN_RUN_SPAN   = 2'd1,
        REG_FIRST_COLUMN   = 2'd2,
        REG_CENTER_COLUMN  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] dark_threshold;
        logic [COL_W-1:0] min_run_span;
        logic [COL_W-1:0] first_column;
        logic [COL_W-1:0] center_column;
    } cfg_t;

    typedef struct packed {
        logic signed [OFF_W-1:0] line_offset;
        logic [COL_W-1:0]        line_span;
        logic                    line_found;
    } result_t;

endpackage

@@ sv/trrf_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// trrf_cfg_regs
// APB register file holding threshold, minimum span and column settings.
// ----------------------------------------------------------------------------
module trrf_cfg_regs
    import trrf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dark_threshold <= RST_DARK_THRESHOLD;
            cfg_reg.min_run_span   <= RST_MIN_RUN_SPAN;
            cfg_reg.first_column   <= RST_FIRST_COLUMN;
            cfg_reg.center_column  <= RST_CENTER_COLUMN;
        end else if (wr_en) begin
            case (idx)
                REG_DARK_THRESHOLD: cfg_reg.dark_threshold <= pwdata[PIX_W-1:0];
                REG_MIN_RUN_SPAN:   cfg_reg.min_run_span   <= pwdata[COL_W-1:0];
                REG_FIRST_COLUMN:   cfg_reg.first_column   <= pwdata[COL_W-1:0];
                REG_CENTER_COLUMN:  cfg_reg.center_column  <= pwdata[COL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_DARK_THRESHOLD: prdata = APB_DW'(cfg_reg.dark_threshold);
            REG_MIN_RUN_SPAN:   prdata = APB_DW'(cfg_reg.min_run_span);
            REG_FIRST_COLUMN:   prdata = APB_DW'(cfg_reg.first_column);
            REG_CENTER_COLUMN:  prdata = APB_DW'(cfg_reg.center_column);
            default:            prdata = '0;
        endcase
    end

endmodule

@@ sv/trrf_row_scan.sv @@
// ----------------------------------------------------------------------------
// trrf_row_scan
// Input register plus per-pixel run tracking and best-run selection.
// Issues one result on the last pixel of each row.
// ----------------------------------------------------------------------------
module trrf_row_scan
    import trrf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [PIX_W-1:0] s_pixel_value,
    input  logic             s_row_last,
    input  logic             res_ready,
    output logic             res_load,
    output result_t          res
);

    // input register
    logic             in_vld_reg;
    logic [PIX_W-1:0] pix_reg;
    logic             last_reg;

    // row state
    logic [COL_W-1:0]     column_reg;
    logic [ROW_CNT_W-1:0] row_cnt_reg;
    logic                 run_open_reg;
    logic [COL_W-1:0]     run_first_reg;
    logic [COL_W-1:0]     run_last_reg;
    logic                 best_vld_reg;
    logic [OFF_W-1:0]     best_off_reg;
    logic [COL_W-1:0]     best_mag_reg;
    logic [COL_W-1:0]     best_span_reg;

    logic                 go;
    logic [COL_W-1:0]     col;
    logic                 in_row;
    logic                 dark;
    logic [COL_W-1:0]     cand_first;
    logic [COL_W-1:0]     cand_last;
    logic                 cand_close;
    logic [COL_W-1:0]     span;
    logic                 qual;
    logic [COL_W:0]       mid_sum;
    logic signed [OFF_W:0] off_wide;
    logic [OFF_W:0]       mag_wide;
    logic [COL_W-1:0]     mag;
    logic                 take;
    logic                 best_vld_next;
    logic [OFF_W-1:0]     best_off_next;
    logic [COL_W-1:0]     best_mag_next;
    logic [COL_W-1:0]     best_span_next;

    // a row-last item waits only if the result register cannot take it
    assign go      = in_vld_reg & (~last_reg | res_ready);
    assign s_ready = ~in_vld_reg | go;

    assign col    = (row_cnt_reg == '0) ? cfg.first_column : column_reg;
    assign in_row = row_cnt_reg < ROW_CNT_W'(ROW_PIXELS_MAX);
    assign dark   = in_row & (pix_reg < cfg.dark_threshold);

    // at most one run closes per item: either the open run ends on a
    // bright pixel, or a dark last pixel closes the run it extends
    assign cand_first = (dark & ~run_open_reg) ? col : run_first_reg;
    assign cand_last  = dark ? col : run_last_reg;
    assign cand_close = dark ? last_reg : run_open_reg;

    assign span     = cand_last - cand_first;
    assign qual     = cand_close & (cand_last >= cand_first) & (span > cfg.min_run_span);
    assign mid_sum  = {1'b0, cand_first} + {1'b0, cand_last};
    assign off_wide = $signed({2'b00, mid_sum[COL_W:1]}) - $signed({2'b00, cfg.center_column});
    assign mag_wide = off_wide[OFF_W] ? (OFF_W+1)'(-off_wide) : (OFF_W+1)'(off_wide);
    assign mag      = mag_wide[COL_W-1:0];
    assign take     = qual & (~best_vld_reg | (mag < best_mag_reg));

    assign best_vld_next  = best_vld_reg | take;
    assign best_off_next  = take ? off_wide[OFF_W-1:0] : best_off_reg;
    assign best_mag_next  = take ? mag : best_mag_reg;
    assign best_span_next = take ? span : best_span_reg;

    assign res_load         = go & last_reg;
    assign res.line_found   = best_vld_next;
    assign res.line_offset  = best_vld_next ? $signed(best_off_next) : '0;
    assign res.line_span    = best_vld_next ? best_span_next : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pix_reg  <= s_pixel_value;
            last_reg <= s_row_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg  <= '0;
            run_open_reg <= 1'b0;
            best_vld_reg <= 1'b0;
        end else if (go) begin
            if (last_reg) begin
                row_cnt_reg  <= '0;
                run_open_reg <= 1'b0;
                best_vld_reg <= 1'b0;
            end else begin
                if (in_row) begin
                    row_cnt_reg <= row_cnt_reg + 1'b1;
                end
                run_open_reg <= dark;
                best_vld_reg <= best_vld_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            column_reg    <= (col < COL_MAX) ? col + 1'b1 : COL_MAX;
            best_off_reg  <= best_off_next;
            best_mag_reg  <= best_mag_next;
            best_span_reg <= best_span_next;
            if (dark && !run_open_reg) begin
                run_first_reg <= col;
            end
            if (dark) begin
                run_last_reg <= col;
            end
        end
    end

endmodule

@@ sv/trrf_result_reg.sv @@
// ----------------------------------------------------------------------------
// trrf_result_reg
// Output register for the per-row result; frees the scan stage from
// downstream backpressure except on row-last items.
// ----------------------------------------------------------------------------
module trrf_result_reg
    import trrf_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    res_load,
    input  result_t                 res,
    output logic                    res_ready,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [OFF_W-1:0] m_line_offset,
    output logic [COL_W-1:0]        m_line_span,
    output logic                    m_line_found
);

    logic    out_vld_reg;
    result_t out_reg;

    assign res_ready     = ~out_vld_reg | m_ready;
    assign m_valid       = out_vld_reg;
    assign m_line_offset = out_reg.line_offset;
    assign m_line_span   = out_reg.line_span;
    assign m_line_found  = out_reg.line_found;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (res_ready) begin
            out_vld_reg <= res_load;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load && res_ready) begin
            out_reg <= res;
        end
    end

endmodule

@@ sv/track_row_run_finder.sv @@
// ----------------------------------------------------------------------------
// track_row_run_finder
// Scan-row dark run detector: reports offset and span of the qualifying
// run nearest the center column at the end of each row.
// ----------------------------------------------------------------------------
// Throughput: one pixel item per clock; the only stall is a row-last item
//   meeting a full result register that is not being drained.
// Result path: a row's last item passes the input register, then the result
//   register, before m_valid rises.
// Reset: synchronous, aresetn low; registers return to defaults and the
//   row state starts fresh at the first_column setting.
module track_row_run_finder
    import trrf_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_AW-1:0]       paddr,
    input  logic [APB_DW-1:0]       pwdata,
    output logic [APB_DW-1:0]       prdata,
    output logic                    pready,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [PIX_W-1:0]        s_pixel_value,
    input  logic                    s_row_last,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [OFF_W-1:0] m_line_offset,
    output logic [COL_W-1:0]        m_line_span,
    output logic                    m_line_found
);

    cfg_t    cfg;
    result_t res;
    logic    res_load;
    logic    res_ready;

    trrf_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    trrf_row_scan u_scan (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_value (s_pixel_value),
        .s_row_last    (s_row_last),
        .res_ready     (res_ready),
        .res_load      (res_load),
        .res           (res)
    );

    trrf_result_reg u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .res_load      (res_load),
        .res           (res),
        .res_ready     (res_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_line_offset (m_line_offset),
        .m_line_span   (m_line_span),
        .m_line_found  (m_line_found)
    );

endmodule

@@ sv/trrf_checker.sv @@
// ----------------------------------------------------------------------------
// trrf_checker
// Port-level checks on the row run finder, bound to the top level.
// ----------------------------------------------------------------------------
module trrf_checker
    import trrf_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    psel,
    input logic                    penable,
    input logic                    pwrite,
    input logic [APB_AW-1:0]       paddr,
    input logic [APB_DW-1:0]       pwdata,
    input logic [APB_DW-1:0]       prdata,
    input logic                    pready,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic [PIX_W-1:0]        s_pixel_value,
    input logic                    s_row_last,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [OFF_W-1:0] m_line_offset,
    input logic [COL_W-1:0]        m_line_span,
    input logic                    m_line_found
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_line_offset)
            && $stable(m_line_span) && $stable(m_line_found))
        else $error("result changed while stalled");

    // empty row reports zeros
    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_line_found |-> m_line_offset == '0 && m_line_span == '0)
        else $error("no-run result carries nonzero fields");

    // a qualifying run always spans more than zero columns
    a_found_span: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_line_found |-> m_line_span != '0)
        else $error("found run with zero span");

    // offset magnitude never exceeds the column range
    a_off_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_line_offset != {1'b1, {(OFF_W-1){1'b0}}})
        else $error("offset out of range");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind track_row_run_finder trrf_checker u_trrf_checker (.*);

@@ sim/track_row_run_finder_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// track_row_run_finder_tb
// Self-checking bench for the scan-row dark run finder. Pixel items go in
// through the valid/ready input, and every row result is checked field by
// field against an in-bench row model or a typed table value. A short
// directed table covers the threshold and column extremes, equal-distance
// runs, runs closed by the row end and column saturation. It is followed
// by random rows under several register setups and idle/stall mixes.
// ----------------------------------------------------------------------------
module track_row_run_finder_tb;
    import trrf_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 100;
    localparam int N_STEPS      = 28;

    typedef enum logic {
        STEP_PIXEL,
        STEP_WRITE
    } step_kind_e;

    typedef struct packed {
        step_kind_e       kind;
        logic [PIX_W-1:0] pix;
        logic             last;
        reg_idx_t         sel;
        logic [COL_W-1:0] val;
        logic             typed;
        result_t          want;
    } step_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_AW-1:0]       paddr;
    logic [APB_DW-1:0]       pwdata;
    logic [APB_DW-1:0]       prdata;
    logic                    pready;
    logic                    s_valid;
    logic                    s_ready;
    logic [PIX_W-1:0]        s_pixel_value;
    logic                    s_row_last;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [OFF_W-1:0] m_line_offset;
    logic [COL_W-1:0]        m_line_span;
    logic                    m_line_found;

    // register shadow
    logic [PIX_W-1:0] cfg_thr;
    logic [COL_W-1:0] cfg_min_span;
    logic [COL_W-1:0] cfg_first_col;
    logic [COL_W-1:0] cfg_center;

    // row model state
    logic [COL_W-1:0] col_q;
    logic             run_open;
    logic [COL_W-1:0] run_first;
    logic [COL_W-1:0] run_last;
    int               best_off;
    int               best_span;
    logic             best_valid;
    int               row_cnt;

    result_t due_results [$];
    step_t   steps [N_STEPS];

    int send_idle_pct;
    int recv_stall_pct;
    int pixels_sent;
    int rows_checked;
    int lines_seen;
    int setups;
    int err_cnt;

    track_row_run_finder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_value (s_pixel_value),
        .s_row_last    (s_row_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_line_offset (m_line_offset),
        .m_line_span   (m_line_span),
        .m_line_found  (m_line_found)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Row model
    // ------------------------------------------------------------------
    function automatic int mag(input int v);
        return (v < 0) ? -v : v;
    endfunction

    task automatic new_row();
        col_q      = cfg_first_col;
        run_open   = 1'b0;
        run_first  = '0;
        run_last   = '0;
        best_off   = 0;
        best_span  = 0;
        best_valid = 1'b0;
        row_cnt    = 0;
    endtask

    task automatic judge_run();
        int span;
        int off;
        if (run_open && run_last >= run_first) begin
            span = int'(run_last) - int'(run_first);
            if (span > int'(cfg_min_span)) begin
                off = ((int'(run_first) + int'(run_last)) / 2) - int'(cfg_center);
                // strict compare keeps the earliest run on equal distance
                if (!best_valid || mag(off) < mag(best_off)) begin
                    best_off   = off;
                    best_span  = span;
                    best_valid = 1'b1;
                end
            end
        end
        run_open = 1'b0;
    endtask

    task automatic score_pixel(input logic [PIX_W-1:0] pix, input logic last);
        logic [COL_W-1:0] col;
        logic             dark;
        result_t          res;
        col  = (row_cnt == 0) ? cfg_first_col : col_q;
        dark = (row_cnt < ROW_PIXELS_MAX) && (pix < cfg_thr);
        if (dark) begin
            if (!run_open) begin
                run_open  = 1'b1;
                run_first = col;
            end
            run_last = col;
        end else begin
            judge_run();
        end
        if (row_cnt < ROW_PIXELS_MAX)
            row_cnt++;
        col_q = (col < COL_MAX) ? col + 1'b1 : COL_MAX;
        if (last) begin
            judge_run();
            res.line_offset = best_valid ? OFF_W'(best_off) : '0;
            res.line_span   = best_valid ? COL_W'(best_span) : '0;
            res.line_found  = best_valid;
            due_results = {due_results, res};
            new_row();
        end
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic last);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_pixel_value <= pix;
        s_row_last    <= last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pixels_sent++;
        score_pixel(pix, last);
    endtask

    // block idle: all rows reported and the input pipe flushed
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input reg_idx_t sel, input logic [COL_W-1:0] val);
        logic [APB_DW-1:0] keep;
        logic [APB_DW-1:0] word;
        keep = (sel == REG_DARK_THRESHOLD) ? APB_DW'(8'hFF) : APB_DW'(10'h3FF);
        // junk in the upper bits must be dropped by the register
        word = ($urandom & ~keep) | (APB_DW'(val) & keep);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({sel, 2'b00});
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        // read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        if (prdata !== (word & keep)) begin
            $error("prdata[%s]: expected %0h, got %0h", sel.name(), word & keep, prdata);
            err_cnt++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        case (sel)
            REG_DARK_THRESHOLD: cfg_thr       = val[PIX_W-1:0];
            REG_MIN_RUN_SPAN:   cfg_min_span  = val;
            REG_FIRST_COLUMN:   cfg_first_col = val;
            REG_CENTER_COLUMN:  cfg_center    = val;
            default: ;
        endcase
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel(input logic want_dark);
        int r;
        r = $urandom_range(19, 0);
        if (r == 0)
            return PIX_W'($urandom_range(255, 0));
        if (want_dark) begin
            if (cfg_thr == 0)
                return PIX_W'($urandom_range(255, 0));
            return (r == 1) ? cfg_thr - 1'b1 : PIX_W'($urandom_range(cfg_thr - 1, 0));
        end
        return (r == 1) ? cfg_thr : PIX_W'($urandom_range(255, cfg_thr));
    endfunction

    task automatic send_random_row();
        int   len;
        int   seg;
        logic want_dark;
        len       = ($urandom_range(9, 0) == 0) ? $urandom_range(90, 25) : $urandom_range(24, 1);
        want_dark = $urandom_range(1, 0);
        seg       = $urandom_range(16, 1);
        for (int i = 0; i < len; i++) begin
            if (seg == 0) begin
                want_dark = !want_dark;
                seg       = $urandom_range(16, 1);
            end
            seg--;
            push_pixel(pick_pixel(want_dark), i == len - 1);
        end
    endtask

    task automatic run_phase(input logic [COL_W-1:0] thr, input logic [COL_W-1:0] min_span,
                             input logic [COL_W-1:0] first_col, input logic [COL_W-1:0] center,
                             input int idle_pct, input int stall_pct);
        int start;
        wait_drained();
        write_register(REG_DARK_THRESHOLD, thr);
        write_register(REG_MIN_RUN_SPAN, min_span);
        write_register(REG_FIRST_COLUMN, first_col);
        write_register(REG_CENTER_COLUMN, center);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start          = pixels_sent;
        while (pixels_sent - start < PHASE_ITEMS)
            send_random_row();
        setups++;
    endtask

    function automatic step_t px(input logic [PIX_W-1:0] pix, input logic last);
        step_t s;
        s       = '0;
        s.kind  = STEP_PIXEL;
        s.pix   = pix;
        s.last  = last;
        return s;
    endfunction

    function automatic step_t px_want(input logic [PIX_W-1:0] pix, input int off,
                                      input int span, input logic found);
        step_t s;
        s                  = px(pix, 1'b1);
        s.typed            = 1'b1;
        s.want.line_offset = OFF_W'(off);
        s.want.line_span   = COL_W'(span);
        s.want.line_found  = found;
        return s;
    endfunction

    function automatic step_t wr(input reg_idx_t sel, input logic [COL_W-1:0] val);
        step_t s;
        s      = '0;
        s.kind = STEP_WRITE;
        s.sel  = sel;
        s.val  = val;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    initial begin
        result_t want;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    $error("unexpected row result: offset %0d span %0d found %0b",
                           m_line_offset, m_line_span, m_line_found);
                    err_cnt++;
                end else begin
                    want = due_results.pop_front();
                    rows_checked++;
                    if (m_line_found === 1'b1)
                        lines_seen++;
                    if (m_line_offset !== want.line_offset) begin
                        $error("line_offset: expected %0d, got %0d",
                               want.line_offset, m_line_offset);
                        err_cnt++;
                    end
                    if (m_line_span !== want.line_span) begin
                        $error("line_span: expected %0d, got %0d", want.line_span, m_line_span);
                        err_cnt++;
                    end
                    if (m_line_found !== want.line_found) begin
                        $error("line_found: expected %0b, got %0b",
                               want.line_found, m_line_found);
                        err_cnt++;
                    end
                end
            end
            m_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        aresetn        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        s_valid        = 1'b0;
        s_pixel_value  = '0;
        s_row_last     = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pixels_sent    = 0;
        rows_checked   = 0;
        lines_seen     = 0;
        setups         = 0;
        err_cnt        = 0;
        cfg_thr        = RST_DARK_THRESHOLD;
        cfg_min_span   = RST_MIN_RUN_SPAN;
        cfg_first_col  = RST_FIRST_COLUMN;
        cfg_center     = RST_CENTER_COLUMN;
        new_row();

        steps = '{
            px_want(8'd255, 0, 0, 1'b0),          // reset values, nothing dark
            px_want(8'd0, 0, 0, 1'b0),            // lone dark pixel has span 0
            wr(REG_MIN_RUN_SPAN, 10'd1),
            wr(REG_FIRST_COLUMN, 10'd0),
            wr(REG_CENTER_COLUMN, 10'd5),
            // two runs at equal distance from center, second one closed by row end
            px(8'd0, 1'b0), px(8'd99, 1'b0), px(8'd50, 1'b0),
            px(8'd100, 1'b0), px(8'd255, 1'b0), px(8'd100, 1'b0), px(8'd200, 1'b0),
            px(8'd128, 1'b0),
            px(8'd99, 1'b0), px(8'd1, 1'b0), px(8'd0, 1'b1),
            wr(REG_DARK_THRESHOLD, 10'd0),
            px_want(8'd0, 0, 0, 1'b0),            // threshold 0: no pixel is dark
            wr(REG_DARK_THRESHOLD, 10'd255),
            px(8'd254, 1'b0), px(8'd0, 1'b0), px(8'd254, 1'b0), px(8'd255, 1'b1),
            wr(REG_MIN_RUN_SPAN, 10'd0),
            wr(REG_FIRST_COLUMN, 10'd1023),
            wr(REG_CENTER_COLUMN, 10'd0),
            px(8'd0, 1'b0), px(8'd0, 1'b1)        // column pinned at 1023
        };

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (steps[i]) begin
            if (steps[i].kind == STEP_WRITE) begin
                wait_drained();
                write_register(steps[i].sel, steps[i].val);
            end else begin
                push_pixel(steps[i].pix, steps[i].last);
                if (steps[i].typed)
                    due_results[due_results.size() - 1] = steps[i].want;
            end
        end
        setups++;

        run_phase(10'd100, 10'd10,   10'd80,   10'd160,  0,  0);
        run_phase(10'd255, 10'd0,    10'd0,    10'd0,    85, 0);
        run_phase(10'd128, 10'd3,    10'd500,  10'd512,  0,  85);
        run_phase(10'd1,   10'd1023, 10'd1023, 10'd1023, 8,  8);
        run_phase(10'd200, 10'd2,    10'd1000, 10'd1010, 0,  0);
        run_phase(10'd150, 10'd0,    10'd0,    10'd1023, 85, 0);
        run_phase(10'd90,  10'd4,    10'd40,   10'd60,   0,  85);
        run_phase(10'd0,   10'd0,    10'd20,   10'd30,   8,  8);

        wait_drained();
        $display("Sent %0d pixel items under %0d register setups and idle mixes.",
                 pixels_sent, setups);
        $display("Checked %0d row results, %0d of them with a qualifying run.",
                 rows_checked, lines_seen);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
